// ===== rtl/core/weighted_range_selector_top_defines.svh =====
// Assertion macros for the weighted range selector.
// Expects clk and arst_n in the scope of each use.
`ifndef WEIGHTED_RANGE_SELECTOR_TOP_DEFINES_SVH
`define WEIGHTED_RANGE_SELECTOR_TOP_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define WRS_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset.
`define WRS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/wrs_pkg.sv =====
// Shared types and constants for the weighted range selector.
// No dependencies.
package wrs_pkg;

	localparam int SLOT_W      = 6;
	localparam int VAL_W       = 32;
	localparam int COUNT_W     = 7;
	localparam int SLOT_LIMIT  = 2 ** SLOT_W;
	localparam int NUM_SLOTS_DEF = 64;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
	localparam logic [VAL_W-1:0]   VAL_MAX   = '1;

	typedef enum logic [1:0] {
		OP_WRITE,
		OP_SKIP,
		OP_LOOKUP
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [SLOT_W-1:0] slot;
		logic [VAL_W-1:0]  low;
		logic [VAL_W-1:0]  high;
		logic [VAL_W-1:0]  probe;
	} cmd_t;

	// queue status seen by front end
	typedef struct packed {
		logic full;
		logic avail;
	} q_stat_t;

	// back end status seen by top level
	typedef struct packed {
		logic lookup_busy;
		logic out_full;
	} back_stat_t;

endpackage

// ===== rtl/core/wrs_if.sv =====
// Request and response channel interfaces for the weighted range selector.
// Depends on wrs_pkg.
interface wrs_req_if;
	logic                        valid;
	logic                        ready;
	logic                        req_type;
	logic [wrs_pkg::SLOT_W-1:0]  slot_id;
	logic [wrs_pkg::VAL_W-1:0]   range_low;
	logic [wrs_pkg::VAL_W-1:0]   range_high;
	logic [wrs_pkg::VAL_W-1:0]   probe_value;

	modport source (output valid, req_type, slot_id, range_low, range_high, probe_value,
		input ready);
	modport sink (input valid, req_type, slot_id, range_low, range_high, probe_value,
		output ready);
endinterface

interface wrs_rsp_if;
	logic                        valid;
	logic                        ready;
	logic                        hit;
	logic [wrs_pkg::SLOT_W-1:0]  found_slot;
	logic [wrs_pkg::VAL_W-1:0]   next_start;
	logic [wrs_pkg::COUNT_W-1:0] entry_total;

	modport source (output valid, hit, found_slot, next_start, entry_total, input ready);
	modport sink (input valid, hit, found_slot, next_start, entry_total, output ready);
endinterface

// ===== rtl/core/wrs_front.sv =====
// Front end: takes request beats and classifies them into commands.
// Depends on wrs_pkg and wrs_req_if.
module wrs_front #(
	parameter int NUM_SLOTS = wrs_pkg::NUM_SLOTS_DEF
) (
	wrs_req_if.sink          req,
	input  wrs_pkg::q_stat_t q_stat,
	output logic             push,
	output wrs_pkg::cmd_t    cmd
);

	assign req.ready = !q_stat.full;
	assign push      = req.valid && !q_stat.full;

	always_comb begin
		cmd.slot  = req.slot_id;
		cmd.low   = req.range_low;
		cmd.high  = req.range_high;
		cmd.probe = req.probe_value;
		if (req.req_type) begin
			cmd.op = wrs_pkg::OP_LOOKUP;
		end else if (32'(req.slot_id) < NUM_SLOTS) begin
			cmd.op = wrs_pkg::OP_WRITE;
		end else begin
			// slot outside the table: report only, no state change
			cmd.op = wrs_pkg::OP_SKIP;
		end
	end

endmodule

// ===== rtl/core/wrs_queue.sv =====
// Short command queue between front and back end.
// Depends on wrs_pkg.
module wrs_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  wrs_pkg::cmd_t    cmd_in,
	input  logic             pop,
	output wrs_pkg::q_stat_t q_stat,
	output wrs_pkg::cmd_t    cmd_out
);

	wrs_pkg::cmd_t                 mem_q [wrs_pkg::QUEUE_DEPTH];
	logic [wrs_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [wrs_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [wrs_pkg::QCNT_W-1:0]    cnt_q;
	logic                          do_push;
	logic                          do_pop;

	localparam logic [wrs_pkg::QPTR_W-1:0] PTR_LAST = wrs_pkg::QPTR_W'(wrs_pkg::QUEUE_DEPTH - 1);
	localparam logic [wrs_pkg::QCNT_W-1:0] CNT_FULL = wrs_pkg::QCNT_W'(wrs_pkg::QUEUE_DEPTH);

	assign q_stat.full  = (cnt_q == CNT_FULL);
	assign q_stat.avail = (cnt_q != '0);
	assign do_push      = push && !q_stat.full;
	assign do_pop       = pop && q_stat.avail;
	assign cmd_out      = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= cmd_in;
		end
	end

endmodule

// ===== rtl/core/wrs_back.sv =====
// Back end: range table, parallel lane compare, priority encode, output register.
// Depends on wrs_pkg and wrs_rsp_if.
module wrs_back #(
	parameter int NUM_SLOTS = wrs_pkg::NUM_SLOTS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                avail,
	input  wrs_pkg::cmd_t       cmd,
	output logic                pop,
	output wrs_pkg::back_stat_t stat,
	wrs_rsp_if.source           rsp
);

	// slot_id is SLOT_W bits, so no lane beyond SLOT_LIMIT is reachable
	localparam int LANES = (NUM_SLOTS < wrs_pkg::SLOT_LIMIT) ? NUM_SLOTS : wrs_pkg::SLOT_LIMIT;

	logic [LANES-1:0]                valid_q;
	logic [wrs_pkg::VAL_W-1:0]       low_q  [LANES];
	logic [wrs_pkg::VAL_W-1:0]       high_q [LANES];
	logic [wrs_pkg::VAL_W-1:0]       next_free_q;
	logic [wrs_pkg::COUNT_W-1:0]     count_q;

	logic                            lk_vld_s1;
	logic [LANES-1:0]                hitvec_s1;

	logic                            out_vld_q;
	logic                            hit_q;
	logic [wrs_pkg::SLOT_W-1:0]      slot_q;
	logic [wrs_pkg::VAL_W-1:0]       start_q;
	logic [wrs_pkg::COUNT_W-1:0]     total_q;

	logic                            can_load;
	logic                            pop_wr;
	logic                            pop_lk;
	logic                            pop_rpt;
	logic [LANES-1:0]                wr_sel;
	logic [LANES-1:0]                lane_hit;
	logic                            is_new;
	logic [wrs_pkg::VAL_W-1:0]       new_start;
	logic [wrs_pkg::COUNT_W-1:0]     new_total;
	logic                            enc_hit;
	logic [wrs_pkg::SLOT_W-1:0]      enc_slot;
	logic                            drain_s1;

	assign can_load = !out_vld_q || rsp.ready;
	// one command at a time; a lookup holds the pop until it has encoded
	assign pop      = avail && !lk_vld_s1 && can_load;
	assign pop_wr   = pop && (cmd.op == wrs_pkg::OP_WRITE);
	assign pop_lk   = pop && (cmd.op == wrs_pkg::OP_LOOKUP);
	assign pop_rpt  = pop && (cmd.op != wrs_pkg::OP_LOOKUP);
	assign drain_s1 = lk_vld_s1 && can_load;

	assign stat.lookup_busy = lk_vld_s1;
	assign stat.out_full    = out_vld_q;

	for (genvar g = 0; g < LANES; g++) begin : g_lane
		assign wr_sel[g]   = pop_wr && (cmd.slot == wrs_pkg::SLOT_W'(g));
		assign lane_hit[g] = valid_q[g] && (low_q[g] <= cmd.probe) && (cmd.probe <= high_q[g]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_q[g] <= 1'b0;
			end else if (wr_sel[g]) begin
				valid_q[g] <= 1'b1;
			end
		end

		always_ff @(posedge clk) begin
			if (wr_sel[g]) begin
				low_q[g]  <= cmd.low;
				high_q[g] <= cmd.high;
			end
		end
	end

	assign is_new    = |(wr_sel & ~valid_q);
	assign new_start = (cmd.high == wrs_pkg::VAL_MAX) ? cmd.high : cmd.high + 1'b1;
	assign new_total = (is_new && count_q != wrs_pkg::COUNT_MAX) ? count_q + 1'b1 : count_q;

	// highest lane wins
	always_comb begin
		enc_hit  = 1'b0;
		enc_slot = '0;
		for (int i = 0; i < LANES; i++) begin
			if (hitvec_s1[i]) begin
				enc_hit  = 1'b1;
				enc_slot = wrs_pkg::SLOT_W'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_free_q <= '0;
			count_q     <= '0;
			lk_vld_s1   <= 1'b0;
			out_vld_q   <= 1'b0;
		end else begin
			if (pop_wr) begin
				next_free_q <= new_start;
				count_q     <= new_total;
			end
			if (pop_lk) begin
				lk_vld_s1 <= 1'b1;
			end else if (drain_s1) begin
				lk_vld_s1 <= 1'b0;
			end
			if (drain_s1 || pop_rpt) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop_lk) begin
			hitvec_s1 <= lane_hit;
		end
		if (drain_s1) begin
			hit_q   <= enc_hit;
			slot_q  <= enc_slot;
			start_q <= next_free_q;
			total_q <= count_q;
		end else if (pop_rpt) begin
			hit_q   <= 1'b0;
			slot_q  <= '0;
			start_q <= pop_wr ? new_start : next_free_q;
			total_q <= pop_wr ? new_total : count_q;
		end
	end

	assign rsp.valid       = out_vld_q;
	assign rsp.hit         = hit_q;
	assign rsp.found_slot  = slot_q;
	assign rsp.next_start  = start_q;
	assign rsp.entry_total = total_q;

endmodule

// ===== rtl/core/weighted_range_selector_top.sv =====
// Weighted range selector top: front end, command queue, back end with range table.
// An insert response beat passes the queue and the output register; a lookup passes the queue,
// the lane compare stage, then the encode into the output register.
// Throughput: one insert per cycle while rsp is ready; a lookup holds the pop until encoded.
// Reset: arst_n clears slot valid bits, next start and entry count at once; no clearing pass.
// Depends on wrs_pkg, wrs_if, wrs_front, wrs_queue, wrs_back and the defines header.
`include "weighted_range_selector_top_defines.svh"

module weighted_range_selector_top #(
	parameter int NUM_SLOTS = wrs_pkg::NUM_SLOTS_DEF
) (
	input logic       clk,
	input logic       arst_n,
	wrs_req_if.sink   req,
	wrs_rsp_if.source rsp
);

	// Front end: a request beat is accepted whenever the queue has room. Inserts
	// to a slot past the table are tagged as report-only so the back end does
	// not need to range-check.
	wrs_pkg::cmd_t       front_cmd;
	logic                front_push;

	// Queue: two entries, so the front keeps taking beats while the back end
	// waits on the response channel or works through a lookup.
	wrs_pkg::q_stat_t    q_stat;
	wrs_pkg::cmd_t       q_cmd;
	logic                q_pop;

	// Back end: each slot is a lane with its own bounds and comparator. A
	// lookup registers the lane hit vector, then a priority encode picks the
	// highest hitting slot into the response register. Valid inserts update the
	// table and answer straight from the new next start and entry count.
	wrs_pkg::back_stat_t back_stat;

	wrs_front #(
		.NUM_SLOTS (NUM_SLOTS)
	) u_front (
		.req    (req),
		.q_stat (q_stat),
		.push   (front_push),
		.cmd    (front_cmd)
	);

	wrs_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (front_push),
		.cmd_in  (front_cmd),
		.pop     (q_pop),
		.q_stat  (q_stat),
		.cmd_out (q_cmd)
	);

	wrs_back #(
		.NUM_SLOTS (NUM_SLOTS)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.avail  (q_stat.avail),
		.cmd    (q_cmd),
		.pop    (q_pop),
		.stat   (back_stat),
		.rsp    (rsp)
	);

	// A lookup in its compare stage owns the back end: nothing else may pop.
	`WRS_ASSERT_SAME(a_no_pop_busy, back_stat.lookup_busy, !q_pop, "pop during lookup")
	// A popped lookup moves into the compare stage.
	`WRS_ASSERT_NEXT(a_lookup_stage, q_pop && q_cmd.op == wrs_pkg::OP_LOOKUP,
		back_stat.lookup_busy, "lookup lost after pop")
	// Misses and insert results always report slot zero.
	`WRS_ASSERT_SAME(a_miss_slot, rsp.valid && !rsp.hit, rsp.found_slot == '0,
		"nonzero slot on miss")
	// The response register is never overwritten while a beat is pending.
	`WRS_ASSERT_SAME(a_no_overrun, back_stat.out_full && !rsp.ready, !q_pop,
		"response overrun")

endmodule
